// ===== rtl/core/nrpt_pkg.sv =====
// Shared types, constants and helper functions for the neighbor proximity table.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package nrpt_pkg;

   typedef enum logic [1:0] {
      OP_OBSERVE = 2'd0,
      OP_EXPIRE  = 2'd1,
      OP_REFRESH = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_OWN_ID       = 3'd0,
      CSR_NEAR_UP      = 3'd1,
      CSR_NEAR_DOWN    = 3'd2,
      CSR_EXPIRE_MS    = 3'd3,
      CSR_DECAY_DELAY  = 3'd4,
      CSR_DECAY_RATE   = 3'd5,
      CSR_PARTY_MIN    = 3'd6,
      CSR_PARTY_WINDOW = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE,
      ST_OBS_RD, ST_OBS_CHK, ST_INS_RD, ST_INS_CHK,
      ST_EXP_RD, ST_EXP_CHK,
      ST_REF_RD, ST_REF_M1, ST_REF_M2, ST_REF_OUT,
      ST_REN_RD, ST_REN_CHK, ST_UP_RD, ST_UP_CHK, ST_DN_RD, ST_DN_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [23:0]        node_id;
      logic [30:0]        time_ms;
      logic signed [7:0]  rssi_dbm;
      logic               heard_partying;
   } req_type;

   typedef struct packed {
      logic [23:0]        entry_id;
      logic signed [7:0]  entry_rssi;
      logic [7:0]         intensity;
      logic               entry_near;
      logic               entry_party_recent;
      logic [6:0]         near_count;
      logic               party_on;
      logic [6:0]         entry_count;
      logic               dropped;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [23:0]        id;
      logic [30:0]        heard;
      logic               heard_ok;
      logic [30:0]        party_time;
      logic               party_ok;
      logic signed [7:0]  rssi;
      logic               near;
      logic               is_self;
   } entry_type;

   localparam logic signed [7:0] NEAR_UP_RESET     = -8'sd69;
   localparam logic signed [7:0] NEAR_DOWN_RESET   = -8'sd75;
   localparam logic [19:0]       EXPIRE_RESET      = 20'd10000;
   localparam logic [19:0]       DECAY_DELAY_RESET = 20'd3000;
   localparam logic [5:0]        DECAY_RATE_RESET  = 6'd5;
   localparam logic [6:0]        PARTY_MIN_RESET   = 7'd3;
   localparam logic [19:0]       PARTY_WIN_RESET   = 20'd3000;
   localparam logic signed [7:0] SELF_RSSI         = 8'sd20;

   localparam logic signed [7:0] INT_FLOOR_DBM = -8'sd90;
   localparam logic signed [7:0] INT_CEIL_DBM  = -8'sd40;
   localparam logic [14:0]       RECIP_50      = 15'd20972;   // ceil(2^20 / 50)

   // Decay products at or beyond this give a drop of 256 dB or more, which is
   // already past every threshold; below it the divide by 1000 is exact.
   localparam logic [36:0]       DECAY_SAT     = 37'd256000;
   localparam logic [18:0]       RECIP_1000    = 19'd268436;  // ceil(2^28 / 1000)

   function automatic logic [31:0] id_hash(input logic [23:0] id);
      logic [31:0] h;
      h = {8'd0, id};
      h = h ^ (h << 13);
      h = h ^ (h >> 17);
      h = h ^ (h << 5);
      return h;
   endfunction

   // (rssi + 90) * 255 / 50, clipped to 0 and 255.
   function automatic logic [7:0] intensity_of(input logic signed [7:0] r);
      logic [8:0]  rx;
      logic [13:0] scaled;
      logic [28:0] prod;
      rx     = 9'({r[7], r} + 9'sd90);
      scaled = 14'(rx[5:0]) * 14'd255;
      prod   = 29'(scaled) * 29'(RECIP_50);
      if (r <= INT_FLOOR_DBM) begin
         return 8'd0;
      end else if (r >= INT_CEIL_DBM) begin
         return 8'd255;
      end
      return prod[27:20];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/neighbor_rssi_proximity_table.sv =====
// Top level of the neighbor proximity table: sequencer, slot memory and result register.
// Depends on nrpt_pkg for the payload structs, state codes and hash/intensity functions.
`default_nettype none

// The table holds up to TABLE_DEPTH neighbor entries in one synchronous memory, kept in
// descending order of a 32-bit xorshift hash of the identifier, with the self entry
// always present. A single read port and a single write port carry every access, and
// each slot visit is a read followed by a check/write step. An observe of a known
// neighbor scans the slots up to the match; an observe of a new neighbor scans all used
// slots and, if there is room, then walks up from the end. Expire visits every used slot.
// Refresh handles each entry in turn (read, decay multiply, divide-by-1000 multiply,
// write back and result) and waits on any output stall, giving one result transfer per
// entry with the near count and party decision on the last one. Every other operation
// gives a single result transfer. After reset the block first writes the self entry into
// slot 0. Writing own_id starts a rename pass that finds the self entry and moves it to
// its new place; requests are held off meanwhile.
module neighbor_rssi_proximity_table
   import nrpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // Configuration registers.
   logic [23:0]       own_id_ff;
   logic signed [7:0] near_up_ff, near_down_ff;
   logic [19:0]       expire_ff, delay_ff, window_ff;
   logic [5:0]        rate_ff;
   logic [6:0]        min_near_ff;

   // Control and working registers.
   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CW-1:0]     put_ff, put_in;
   logic              party_latch_ff, party_latch_in;
   logic              ren_pend_ff, ren_pend_in;
   logic              drop_ff, drop_in;
   entry_type         cur_ff, cur_in;
   logic [36:0]       p_ff, p_in;
   logic [8:0]        q_ff, q_in;
   logic              decay_on_ff, decay_on_in;
   logic              recent_ff, recent_in;
   logic [6:0]        near_cnt_ff, near_cnt_in;
   logic              recent_any_ff, recent_any_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Slot memory.
   entry_type         slot_mem [TABLE_DEPTH];
   entry_type         mem_rdata_ff;
   logic              mem_we, mem_re;
   logic [IW-1:0]     mem_waddr, mem_raddr;
   entry_type         mem_wdata;

   // Shared combinational terms.
   entry_type          rd;
   logic [31:0]        rd_hash, cur_hash;
   logic               out_free, req_fire, scan_end;
   logic [CW-1:0]      scan_nx, put_nx, put_pv;
   logic signed [32:0] now_s, rd_age, excess, party_age;
   logic signed [8:0]  err, half;
   logic [36:0]        q_prod;
   logic signed [9:0]  dec;
   logic               near_new, gone, cnt_hit;
   logic [6:0]         cnt_new;
   entry_type          upd;

   assign rd        = mem_rdata_ff;
   assign rd_hash   = id_hash(rd.id);
   assign cur_hash  = id_hash(cur_ff.id);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign scan_nx   = scan_ff + CW'(1);
   assign put_nx    = put_ff + CW'(1);
   assign put_pv    = put_ff - CW'(1);
   assign scan_end  = (scan_nx == used_ff);

   assign now_s     = $signed({2'b00, req_ff.time_ms});
   assign rd_age    = now_s - $signed({2'b00, rd.heard});
   assign excess    = rd_age - $signed({13'd0, delay_ff});
   assign party_age = now_s - $signed({2'b00, rd.party_time});
   assign gone      = !rd.is_self && rd.heard_ok && (rd_age > $signed({13'd0, expire_ff}));

   // Observe smoothing: move halfway to the new reading, rounding toward zero.
   assign err  = $signed({req_ff.rssi_dbm[7], req_ff.rssi_dbm}) - $signed({rd.rssi[7], rd.rssi});
   assign half = $signed(err + $signed({8'd0, err[8]})) >>> 1;

   assign q_prod = 37'(p_ff[17:0]) * 37'(RECIP_1000);

   // Decayed rssi and near hysteresis for the entry held in cur_ff.
   assign dec = $signed({{2{cur_ff.rssi[7]}}, cur_ff.rssi})
              - (decay_on_ff ? $signed({1'b0, q_ff}) : 10'sd0);
   always_comb begin
      near_new = cur_ff.near;
      if (dec >= $signed({{2{near_up_ff[7]}}, near_up_ff}) && !cur_ff.near) begin
         near_new = 1'b1;
      end else if (dec <= $signed({{2{near_down_ff[7]}}, near_down_ff}) && cur_ff.near) begin
         near_new = 1'b0;
      end
   end
   assign cnt_new = near_cnt_ff + 7'(near_new);
   assign cnt_hit = (cnt_new >= min_near_ff);

   always_comb begin
      upd            = rd;
      upd.heard      = req_ff.time_ms;
      upd.heard_ok   = 1'b1;
      upd.rssi       = 8'(rd.rssi + half[7:0]);
      upd.party_time = req_ff.time_ms;
      upd.party_ok   = req_ff.heard_partying;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (ren_pend_ff) begin
               state_in = ST_REN_RD;
            end else if (req_fire) begin
               unique case (req_data.opcode)
                  OP_OBSERVE: state_in = ST_OBS_RD;
                  OP_EXPIRE:  state_in = ST_EXP_RD;
                  OP_REFRESH: state_in = ST_REF_RD;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_OBS_RD:  state_in = ST_OBS_CHK;
         ST_OBS_CHK: begin
            if (rd.id == req_ff.node_id) begin
               state_in = ST_RESP;
            end else if (scan_end) begin
               state_in = (used_ff < DEPTH_C) ? ST_INS_RD : ST_RESP;
            end else begin
               state_in = ST_OBS_RD;
            end
         end
         ST_INS_RD:  state_in = (put_ff == '0) ? ST_RESP : ST_INS_CHK;
         ST_INS_CHK: state_in = (cur_hash > rd_hash) ? ST_INS_RD : ST_RESP;
         ST_EXP_RD:  state_in = ST_EXP_CHK;
         ST_EXP_CHK: state_in = scan_end ? ST_RESP : ST_EXP_RD;
         ST_REF_RD:  state_in = ST_REF_M1;
         ST_REF_M1:  state_in = ST_REF_M2;
         ST_REF_M2:  state_in = ST_REF_OUT;
         ST_REF_OUT: begin
            if (out_free) begin
               state_in = scan_end ? ST_IDLE : ST_REF_RD;
            end
         end
         ST_REN_RD:  state_in = ST_REN_CHK;
         ST_REN_CHK: begin
            if (rd.is_self) begin
               state_in = ST_UP_RD;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REN_RD;
            end
         end
         ST_UP_RD:   state_in = (put_ff == '0) ? ST_DN_RD : ST_UP_CHK;
         ST_UP_CHK:  state_in = (cur_hash > rd_hash) ? ST_UP_RD : ST_DN_RD;
         ST_DN_RD:   state_in = (put_nx >= used_ff) ? ST_IDLE : ST_DN_CHK;
         ST_DN_CHK:  state_in = (cur_hash < rd_hash) ? ST_DN_RD : ST_IDLE;
         ST_RESP:    state_in = out_free ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory control and result register loads.
   always_comb begin
      req_ready      = 1'b0;
      req_in         = req_ff;
      used_in        = used_ff;
      scan_in        = scan_ff;
      put_in         = put_ff;
      party_latch_in = party_latch_ff;
      ren_pend_in    = ren_pend_ff;
      drop_in        = drop_ff;
      cur_in         = cur_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      decay_on_in    = decay_on_ff;
      recent_in      = recent_ff;
      near_cnt_in    = near_cnt_ff;
      recent_any_in  = recent_any_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = put_ff[IW-1:0];
      mem_raddr      = scan_ff[IW-1:0];
      mem_wdata      = cur_ff;

      unique case (state_ff)
         ST_INIT: begin
            mem_we             = 1'b1;
            mem_waddr          = '0;
            mem_wdata          = '0;
            mem_wdata.id       = own_id_ff;
            mem_wdata.rssi     = SELF_RSSI;
            mem_wdata.near     = 1'b1;
            mem_wdata.is_self  = 1'b1;
         end
         ST_IDLE: begin
            req_ready = !ren_pend_ff;
            scan_in   = '0;
            put_in    = '0;
            if (ren_pend_ff) begin
               ren_pend_in = 1'b0;
            end else if (req_fire) begin
               req_in        = req_data;
               drop_in       = 1'b0;
               near_cnt_in   = '0;
               recent_any_in = 1'b0;
            end
         end
         ST_OBS_RD, ST_EXP_RD, ST_REF_RD, ST_REN_RD: begin
            mem_re = 1'b1;
         end
         ST_OBS_CHK: begin
            if (rd.id == req_ff.node_id) begin
               if (!rd.heard_ok || req_ff.time_ms > rd.heard) begin
                  mem_we    = 1'b1;
                  mem_waddr = scan_ff[IW-1:0];
                  mem_wdata = upd;
               end
            end else if (scan_end) begin
               if (used_ff < DEPTH_C) begin
                  cur_in.id         = req_ff.node_id;
                  cur_in.heard      = req_ff.time_ms;
                  cur_in.heard_ok   = 1'b1;
                  cur_in.party_time = req_ff.time_ms;
                  cur_in.party_ok   = req_ff.heard_partying;
                  cur_in.rssi       = req_ff.rssi_dbm;
                  cur_in.near       = (req_ff.rssi_dbm >= near_up_ff);
                  cur_in.is_self    = 1'b0;
                  put_in            = used_ff;
               end else begin
                  drop_in = 1'b1;
               end
            end else begin
               scan_in = scan_nx;
            end
         end
         ST_INS_RD: begin
            if (put_ff == '0) begin
               mem_we  = 1'b1;
               used_in = used_ff + CW'(1);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = put_pv[IW-1:0];
            end
         end
         ST_INS_CHK: begin
            mem_we = 1'b1;
            if (cur_hash > rd_hash) begin
               mem_wdata = rd;
               put_in    = put_pv;
            end else begin
               used_in = used_ff + CW'(1);
            end
         end
         ST_EXP_CHK: begin
            // Survivors are packed down toward slot 0 in their original order.
            scan_in = scan_nx;
            if (!gone) begin
               mem_we    = 1'b1;
               mem_wdata = rd;
               put_in    = put_nx;
            end
            if (scan_end) begin
               used_in = gone ? put_ff : put_nx;
            end
         end
         ST_REF_M1: begin
            cur_in      = rd;
            decay_on_in = rd.heard_ok && (rd_age > $signed({13'd0, delay_ff}));
            p_in        = 37'(rate_ff) * 37'(excess[30:0]);
            recent_in   = rd.party_ok && (party_age < $signed({13'd0, window_ff}));
         end
         ST_REF_M2: begin
            q_in = (p_ff >= DECAY_SAT) ? 9'd256 : q_prod[36:28];
         end
         ST_REF_OUT: begin
            if (out_free) begin
               mem_we                         = 1'b1;
               mem_waddr                      = scan_ff[IW-1:0];
               mem_wdata.near                 = near_new;
               near_cnt_in                    = cnt_new;
               recent_any_in                  = recent_any_ff || recent_ff;
               scan_in                        = scan_nx;
               rsp_valid_in                   = 1'b1;
               rsp_data_in                    = '0;
               rsp_data_in.entry_id           = cur_ff.id;
               rsp_data_in.entry_rssi         = cur_ff.rssi;
               rsp_data_in.intensity          = intensity_of(cur_ff.rssi);
               rsp_data_in.entry_near         = near_new;
               rsp_data_in.entry_party_recent = recent_ff;
               rsp_data_in.entry_count        = 7'(used_ff);
               if (scan_end) begin
                  party_latch_in           = cnt_hit;
                  rsp_data_in.near_count   = cnt_new;
                  rsp_data_in.party_on     = recent_any_ff || recent_ff || cnt_hit;
                  rsp_data_in.last         = 1'b1;
               end
            end
         end
         ST_REN_CHK: begin
            if (rd.is_self) begin
               cur_in    = rd;
               cur_in.id = own_id_ff;
               put_in    = scan_ff;
            end else begin
               scan_in = scan_nx;
            end
         end
         ST_UP_RD: begin
            if (put_ff != '0) begin
               mem_re    = 1'b1;
               mem_raddr = put_pv[IW-1:0];
            end
         end
         ST_UP_CHK: begin
            if (cur_hash > rd_hash) begin
               mem_we    = 1'b1;
               mem_wdata = rd;
               put_in    = put_pv;
            end
         end
         ST_DN_RD: begin
            if (put_nx >= used_ff) begin
               mem_we = 1'b1;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = put_nx[IW-1:0];
            end
         end
         ST_DN_CHK: begin
            mem_we = 1'b1;
            if (cur_hash < rd_hash) begin
               mem_wdata = rd;
               put_in    = put_nx;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.entry_count = 7'(used_ff);
               rsp_data_in.dropped     = drop_ff;
               rsp_data_in.last        = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // A new own_id always schedules a rename pass, even while one is running.
      if (csr_we && (csr_index == CSR_OWN_ID)) begin
         ren_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= slot_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff    <= '0;
         near_up_ff   <= NEAR_UP_RESET;
         near_down_ff <= NEAR_DOWN_RESET;
         expire_ff    <= EXPIRE_RESET;
         delay_ff     <= DECAY_DELAY_RESET;
         rate_ff      <= DECAY_RATE_RESET;
         min_near_ff  <= PARTY_MIN_RESET;
         window_ff    <= PARTY_WIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ID:       own_id_ff    <= csr_wdata;
            CSR_NEAR_UP:      near_up_ff   <= csr_wdata[7:0];
            CSR_NEAR_DOWN:    near_down_ff <= csr_wdata[7:0];
            CSR_EXPIRE_MS:    expire_ff    <= csr_wdata[19:0];
            CSR_DECAY_DELAY:  delay_ff     <= csr_wdata[19:0];
            CSR_DECAY_RATE:   rate_ff      <= csr_wdata[5:0];
            CSR_PARTY_MIN:    min_near_ff  <= csr_wdata[6:0];
            CSR_PARTY_WINDOW: window_ff    <= csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         used_ff        <= CW'(1);
         party_latch_ff <= 1'b0;
         ren_pend_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         party_latch_ff <= party_latch_in;
         ren_pend_ff    <= ren_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_ff       <= scan_in;
      put_ff        <= put_in;
      drop_ff       <= drop_in;
      cur_ff        <= cur_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      decay_on_ff   <= decay_on_in;
      recent_ff     <= recent_in;
      near_cnt_ff   <= near_cnt_in;
      recent_any_ff <= recent_any_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sim/nrpt_table_checker.sv =====
// Checker for the neighbor proximity table: watches the request, result and register ports,
// keeps its own copy of the table and compares every result transfer. Depends on nrpt_pkg.
module nrpt_table_checker
   import nrpt_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   output int               fail_count,
   output int               reports_due
);

   logic [23:0] cfg_own;
   int          cfg_up, cfg_down;
   longint      cfg_expire, cfg_delay, cfg_rate, cfg_window;
   int          cfg_min_near;

   logic [23:0] tab_id[DEPTH];
   logic [30:0] tab_heard[DEPTH];
   bit          tab_heard_ok[DEPTH];
   logic [30:0] tab_party[DEPTH];
   bit          tab_party_ok[DEPTH];
   int          tab_rssi[DEPTH];
   bit          tab_near[DEPTH];
   bit          tab_self[DEPTH];
   int          tab_used;
   bit          party_latched;

   rsp_type     expected_reports[$];

   assign reports_due = expected_reports.size();

   function automatic logic [31:0] mix32(logic [23:0] id);
      logic [31:0] h;
      h = {8'd0, id};
      h = h ^ (h << 13);
      h = h ^ (h >> 17);
      h = h ^ (h << 5);
      return h;
   endfunction

   function automatic int level_of(int r);
      if (r <= -90) return 0;
      if (r >= -40) return 255;
      return ((r + 90) * 255) / 50;
   endfunction

   // Append one expected result at the tail of the queue.
   function automatic void enqueue_report(rsp_type r);
      expected_reports = {expected_reports, r};
   endfunction

   function automatic void swap_slots(int a, int b);
      logic [23:0] id;
      logic [30:0] t;
      bit          f;
      int          r;
      id = tab_id[a];       tab_id[a] = tab_id[b];             tab_id[b] = id;
      t = tab_heard[a];     tab_heard[a] = tab_heard[b];       tab_heard[b] = t;
      f = tab_heard_ok[a];  tab_heard_ok[a] = tab_heard_ok[b]; tab_heard_ok[b] = f;
      t = tab_party[a];     tab_party[a] = tab_party[b];       tab_party[b] = t;
      f = tab_party_ok[a];  tab_party_ok[a] = tab_party_ok[b]; tab_party_ok[b] = f;
      r = tab_rssi[a];      tab_rssi[a] = tab_rssi[b];         tab_rssi[b] = r;
      f = tab_near[a];      tab_near[a] = tab_near[b];         tab_near[b] = f;
      f = tab_self[a];      tab_self[a] = tab_self[b];         tab_self[b] = f;
   endfunction

   // Bubble one slot to its place in descending hash order; equal hashes stay put.
   function automatic void reorder(int i);
      while (i > 0 && mix32(tab_id[i]) > mix32(tab_id[i-1])) begin
         swap_slots(i, i - 1);
         i--;
      end
      while (i + 1 < tab_used && mix32(tab_id[i]) < mix32(tab_id[i+1])) begin
         swap_slots(i, i + 1);
         i++;
      end
   endfunction

   function automatic void table_reset();
      cfg_own = '0;
      cfg_up = -69;
      cfg_down = -75;
      cfg_expire = 10000;
      cfg_delay = 3000;
      cfg_rate = 5;
      cfg_min_near = 3;
      cfg_window = 3000;
      for (int i = 0; i < DEPTH; i++) begin
         tab_id[i] = '0; tab_heard[i] = '0; tab_heard_ok[i] = 0; tab_party[i] = '0;
         tab_party_ok[i] = 0; tab_rssi[i] = 0; tab_near[i] = 0; tab_self[i] = 0;
      end
      tab_rssi[0] = 20;
      tab_near[0] = 1;
      tab_self[0] = 1;
      tab_used = 1;
      party_latched = 0;
      expected_reports.delete();
   endfunction

   function automatic void register_write(logic [2:0] idx, logic [23:0] v);
      case (csr_index_type'(idx))
         CSR_OWN_ID: begin
            cfg_own = v;
            for (int i = 0; i < tab_used; i++) begin
               if (tab_self[i]) begin
                  tab_id[i] = v;
                  reorder(i);
                  break;
               end
            end
         end
         CSR_NEAR_UP:      cfg_up = int'($signed(v[7:0]));
         CSR_NEAR_DOWN:    cfg_down = int'($signed(v[7:0]));
         CSR_EXPIRE_MS:    cfg_expire = longint'(v[19:0]);
         CSR_DECAY_DELAY:  cfg_delay = longint'(v[19:0]);
         CSR_DECAY_RATE:   cfg_rate = longint'(v[5:0]);
         CSR_PARTY_MIN:    cfg_min_near = int'(v[6:0]);
         CSR_PARTY_WINDOW: cfg_window = longint'(v[19:0]);
         default: ;
      endcase
   endfunction

   // Apply one request to the table and queue the results it must produce.
   function automatic void table_apply(req_type rq);
      rsp_type r;
      longint  now, dec;
      int      rssi, near_cnt, k;
      bit      found, recent, any_recent;
      now = longint'(rq.time_ms);
      rssi = int'(rq.rssi_dbm);
      if (rq.opcode == OP_REFRESH) begin
         near_cnt = 0;
         any_recent = 0;
         for (int i = 0; i < tab_used; i++) begin
            dec = tab_rssi[i];
            if (tab_heard_ok[i] && now - longint'(tab_heard[i]) > cfg_delay)
               dec = tab_rssi[i] - (cfg_rate * (now - longint'(tab_heard[i]) - cfg_delay)) / 1000;
            if (dec >= cfg_up && !tab_near[i]) tab_near[i] = 1;
            else if (dec <= cfg_down && tab_near[i]) tab_near[i] = 0;
            recent = tab_party_ok[i] && (now - longint'(tab_party[i]) < cfg_window);
            if (tab_near[i]) near_cnt++;
            if (recent) any_recent = 1;
            r = '0;
            r.entry_id = tab_id[i];
            r.entry_rssi = 8'(tab_rssi[i]);
            r.intensity = 8'(level_of(tab_rssi[i]));
            r.entry_near = tab_near[i];
            r.entry_party_recent = recent;
            r.entry_count = 7'(tab_used);
            enqueue_report(r);
         end
         party_latched = near_cnt >= cfg_min_near;
         r = expected_reports.pop_back();
         r.near_count = 7'(near_cnt);
         r.party_on = any_recent || party_latched;
         r.last = 1;
         enqueue_report(r);
         return;
      end
      r = '0;
      if (rq.opcode == OP_OBSERVE) begin
         found = 0;
         for (int i = 0; i < tab_used; i++) begin
            if (tab_id[i] == rq.node_id) begin
               if (!tab_heard_ok[i] || rq.time_ms > tab_heard[i]) begin
                  tab_heard[i] = rq.time_ms;
                  tab_heard_ok[i] = 1;
                  tab_rssi[i] = tab_rssi[i] + (rssi - tab_rssi[i]) / 2;
                  tab_party[i] = rq.time_ms;
                  tab_party_ok[i] = rq.heard_partying;
               end
               found = 1;
               break;
            end
         end
         if (!found) begin
            if (tab_used < DEPTH) begin
               k = tab_used;
               tab_id[k] = rq.node_id;
               tab_heard[k] = rq.time_ms;
               tab_heard_ok[k] = 1;
               tab_party[k] = rq.time_ms;
               tab_party_ok[k] = rq.heard_partying;
               tab_rssi[k] = rssi;
               tab_near[k] = rssi >= cfg_up;
               tab_self[k] = 0;
               tab_used++;
               reorder(k);
            end else begin
               r.dropped = 1;
            end
         end
      end else if (rq.opcode == OP_EXPIRE) begin
         k = 0;
         for (int i = 0; i < tab_used; i++) begin
            if (!(!tab_self[i] && tab_heard_ok[i] && now - longint'(tab_heard[i]) > cfg_expire))
            begin
               if (k != i) swap_slots(k, i);
               k++;
            end
         end
         tab_used = k;
      end
      r.entry_count = 7'(tab_used);
      r.last = 1;
      enqueue_report(r);
   endfunction

   function automatic void compare_report(rsp_type got, rsp_type want);
      if (got.entry_id !== want.entry_id) begin
         $error("entry_id: expected %0h, actual %0h", want.entry_id, got.entry_id);
         fail_count++;
      end
      if (got.entry_rssi !== want.entry_rssi) begin
         $error("entry_rssi: expected %0d, actual %0d", want.entry_rssi, got.entry_rssi);
         fail_count++;
      end
      if (got.intensity !== want.intensity) begin
         $error("intensity: expected %0d, actual %0d", want.intensity, got.intensity);
         fail_count++;
      end
      if (got.entry_near !== want.entry_near) begin
         $error("entry_near: expected %0d, actual %0d", want.entry_near, got.entry_near);
         fail_count++;
      end
      if (got.entry_party_recent !== want.entry_party_recent) begin
         $error("entry_party_recent: expected %0d, actual %0d",
                want.entry_party_recent, got.entry_party_recent);
         fail_count++;
      end
      if (got.near_count !== want.near_count) begin
         $error("near_count: expected %0d, actual %0d", want.near_count, got.near_count);
         fail_count++;
      end
      if (got.party_on !== want.party_on) begin
         $error("party_on: expected %0d, actual %0d", want.party_on, got.party_on);
         fail_count++;
      end
      if (got.entry_count !== want.entry_count) begin
         $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
         fail_count++;
      end
      if (got.dropped !== want.dropped) begin
         $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         table_reset();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result transfer with no result expected");
               fail_count++;
            end else begin
               compare_report(rsp_data, expected_reports.pop_front());
            end
         end
         if (csr_we) register_write(csr_index, csr_wdata);
         if (req_valid && req_ready) table_apply(req_data);
      end
   end

endmodule

// ===== sim/neighbor_rssi_proximity_table_tb.sv =====
// Testbench top for the neighbor proximity table: clock, reset, stimulus and the verdict.
// Depends on nrpt_pkg, the block itself and nrpt_table_checker.
module neighbor_rssi_proximity_table_tb;
   import nrpt_pkg::*;

   // A run with no transfer for this many cycles is taken as a hang. The slowest correct
   // operation is a refresh of a full table with every result stalled.
   localparam int HANG_LIMIT  = 20000;
   localparam int POOL_SIZE   = 20;
   localparam int TABLE_DEPTH = 16;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   int          fail_count;
   int          reports_due;
   int          quiet_cycles = 0;
   bit          no_gaps = 0;
   logic [30:0] clock_ms = '0;
   logic [23:0] id_pool[POOL_SIZE];

   neighbor_rssi_proximity_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   nrpt_table_checker #(
      .DEPTH(TABLE_DEPTH)
   ) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .reports_due(reports_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hang detection: any transfer or register write counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("neighbor_rssi_proximity_table_tb NOT OK");
         $finish;
      end
   end

   // Result side: for every transfer, hold ready low for a random number of cycles first.
   // During a no-gap stretch ready stays high so results stream back to back.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Present one request. The task returns at the edge where the transfer happened, with
   // valid still high, so a following request with no gap keeps valid up without a glitch.
   task automatic send_op(opcode_type op, logic [23:0] id, logic [30:0] t_ms, int rssi,
                          bit party);
      req_type item;
      int      gap;
      item.opcode = op;
      item.node_id = id;
      item.time_ms = t_ms;
      item.rssi_dbm = 8'(rssi);
      item.heard_partying = party;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Bring the block to rest: drop valid, let every expected result arrive, then wait out
   // any trailing write-back inside the block.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 0;
      while (reports_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Register writes are issued on consecutive cycles; the caller lowers the enable.
   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic write_all(logic [23:0] own, int up, int down, logic [19:0] expire_ms,
                            logic [19:0] delay_ms, logic [5:0] rate, logic [6:0] min_near,
                            logic [19:0] window_ms);
      write_reg(CSR_OWN_ID, own);
      write_reg(CSR_NEAR_UP, {16'd0, 8'(up)});
      write_reg(CSR_NEAR_DOWN, {16'd0, 8'(down)});
      write_reg(CSR_EXPIRE_MS, {4'd0, expire_ms});
      write_reg(CSR_DECAY_DELAY, {4'd0, delay_ms});
      write_reg(CSR_DECAY_RATE, {18'd0, rate});
      write_reg(CSR_PARTY_MIN, {17'd0, min_near});
      write_reg(CSR_PARTY_WINDOW, {4'd0, window_ms});
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Random traffic of one phase. Most time stamps move forward by up to a few seconds so
   // that decay, hysteresis, windows and expiry all see realistic silences; a few jump
   // anywhere in the 31-bit range, which also gives stale and future stamps.
   task automatic random_phase(int count);
      int          pick;
      logic [23:0] id;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) clock_ms = 31'($urandom());
         else clock_ms = 31'(clock_ms + $urandom_range(0, 3000));
         pick = $urandom_range(0, 99);
         id = ($urandom_range(0, 9) == 0) ? 24'($urandom()) :
              id_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 60) begin
            send_op(OP_OBSERVE, id, clock_ms, $urandom_range(0, 147) - 127,
                    $urandom_range(0, 1));
         end else if (pick < 75) begin
            send_op(OP_EXPIRE, 24'($urandom()), clock_ms, $urandom_range(0, 147) - 127,
                    $urandom_range(0, 1));
         end else if (pick < 96) begin
            send_op(OP_REFRESH, 24'($urandom()), clock_ms, $urandom_range(0, 147) - 127,
                    $urandom_range(0, 1));
         end else begin
            send_op(OP_NONE, 24'($urandom()), clock_ms, $urandom_range(0, 147) - 127,
                    $urandom_range(0, 1));
         end
      end
   endtask

   initial begin
      // A pool a little larger than the table makes it fill up and refuse newcomers.
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 24'($urandom());
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part under the reset settings. The self entry starts with id 0, so an
      // observe of id 0 stamps the self entry rather than inserting a neighbor.
      send_op(OP_REFRESH, 24'h0, 31'h0, 0, 0);
      send_op(OP_OBSERVE, 24'h000000, 31'd100, -127, 1);
      send_op(OP_OBSERVE, 24'hFFFFFF, 31'h7FFFFFFF, -127, 1);
      send_op(OP_OBSERVE, 24'h123456, 31'd200, 20, 0);
      send_op(OP_OBSERVE, 24'h123456, 31'd150, -60, 1);     // stale stamp is ignored
      send_op(OP_OBSERVE, 24'h123456, 31'd250, -100, 1);
      send_op(OP_OBSERVE, 24'h00FF00, 31'd300, -69, 0);     // exactly at the near threshold
      send_op(OP_REFRESH, 24'h0, 31'd0, 0, 0);              // stamps in the future
      send_op(OP_REFRESH, 24'h0, 31'd2000, 0, 0);
      send_op(OP_REFRESH, 24'h0, 31'd20000, 0, 0);          // long silence decays rssi
      send_op(OP_NONE, 24'hABCDEF, 31'd20000, 5, 1);
      send_op(OP_EXPIRE, 24'h0, 31'd12000, 0, 0);
      send_op(OP_REFRESH, 24'h0, 31'h7FFFFFFF, -127, 1);
      send_op(OP_EXPIRE, 24'hFFFFFF, 31'h7FFFFFFF, 20, 1);  // keeps the self entry and id FFFFFF
      send_op(OP_REFRESH, 24'h0, 31'h7FFFFFFF, 0, 0);
      settle_block();

      // Lowest settings: everything expires and decays at once, no hysteresis band.
      write_all(24'h000001, -127, -127, 20'd0, 20'd0, 6'd0, 7'd0, 20'd0);
      clock_ms = 31'd1000;
      random_phase(25);
      settle_block();

      // Highest settings but near thresholds at 20, with a back-to-back stretch on both sides.
      no_gaps = 1;
      write_all(24'hFFFFFF, 20, 20, 20'hFFFFF, 20'hFFFFF, 6'd63, 7'd127, 20'hFFFFF);
      random_phase(25);
      settle_block();
      no_gaps = 0;

      // Realistic settings, each phase renaming the self entry to a fresh id.
      for (int ph = 0; ph < 4; ph++) begin
         int up;
         up = $urandom_range(0, 40) - 90;
         write_all(24'($urandom()), up, up - $urandom_range(0, 12),
                   20'($urandom_range(1000, 20000)), 20'($urandom_range(0, 6000)),
                   6'($urandom_range(0, 63)), 7'($urandom_range(0, 6)),
                   20'($urandom_range(0, 8000)));
         random_phase(25);
         settle_block();
      end

      repeat (50) @(negedge clock);
      if (fail_count == 0 && reports_due == 0) begin
         $display("neighbor_rssi_proximity_table_tb OK");
      end else begin
         $display("neighbor_rssi_proximity_table_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/nrpt_pkg.sv
rtl/core/neighbor_rssi_proximity_table.sv
sim/nrpt_table_checker.sv
sim/neighbor_rssi_proximity_table_tb.sv
